@@ sv/assert_macros.svh @@
// assertion macros for the checker module
// no dependencies; expects a clock named i_clk and a reset named i_rst_n
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked out of reset
`define ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, checked out of reset
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ sv/f2m_pkg.sv @@
// constants, types and elaboration-time tables for the frequency to note block
// no dependencies
package f2m_pkg;

    localparam int LOG_TABLE_ENTRIES = 256;
    localparam int FREQ_FRAC_BITS    = 4;

    localparam int FREQ_W     = 18;
    localparam int REF_W      = 16;
    localparam int MANT_W     = FREQ_W - 1;
    localparam int EXP_W      = $clog2(FREQ_W);
    localparam int Q          = 24;
    localparam int TAB_W      = Q + 1;
    localparam int TAB_IDX_W  = $clog2(LOG_TABLE_ENTRIES + 1);
    localparam int N_MUL_W    = MANT_W + TAB_IDX_W;
    localparam int LOG_W      = Q + EXP_W;
    localparam int L_W        = LOG_W + 2;
    localparam int S_W        = L_W + 4;
    localparam int RND_W      = S_W - Q;

    localparam int U_W  = 27;
    localparam int T_W  = 26;
    localparam int T2_W = 22;
    localparam int T3_W = 18;
    localparam int T4_W = 14;
    localparam int E_W  = 27;
    localparam int G_W  = 26;
    localparam int X_W  = 35;
    localparam int QE_W = 8;
    localparam int RCP_W = 16;
    localparam int RCP_SH = 40;

    localparam logic [63:0] LN2_Q30 = 64'd744261118;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_BELOW = 2'd1;
    localparam logic [1:0] ST_ABOVE = 2'd2;

    localparam logic [1:0] REG_REFERENCE = 2'd0;
    localparam logic [1:0] REG_MIN_FREQ  = 2'd1;
    localparam logic [1:0] REG_MAX_FREQ  = 2'd2;

    localparam logic [FREQ_W-1:0] MIN_FREQ_RST = FREQ_W'(120);
    localparam logic [FREQ_W-1:0] MAX_FREQ_RST = FREQ_W'(206592);
    localparam logic [REF_W-1:0]  REF_RST      = REF_W'(8372);

    typedef logic [TAB_W-1:0] t_log_tab [0:LOG_TABLE_ENTRIES];

    typedef struct packed {
        logic [1:0] status;
        logic [6:0] note;
        logic       minus;
    } t_side;

    // log2 of x in [1,2] (q30) by repeated squaring, q24 result
    function automatic logic [TAB_W-1:0] log2_mant(input logic [63:0] x0);
        logic [63:0]      x;
        logic [TAB_W-1:0] res;
        x   = x0;
        res = '0;
        if (x >= 64'h8000_0000) begin
            res = TAB_W'(1) << Q;
        end else begin
            for (int b = Q - 1; b >= 0; b--) begin
                x = (x * x) >> 30;
                if (x >= 64'h8000_0000) begin
                    res[b] = 1'b1;
                    x      = x >> 1;
                end
            end
        end
        return res;
    endfunction

    function automatic t_log_tab build_log_tab();
        t_log_tab tab;
        for (int i = 0; i <= LOG_TABLE_ENTRIES; i++) begin
            tab[i] = log2_mant(64'h4000_0000 + ((64'(i) << 30) / LOG_TABLE_ENTRIES));
        end
        return tab;
    endfunction

    localparam t_log_tab LOG_TAB = build_log_tab();

    // series value at one full semitone, evaluated at elaboration
    function automatic logic [63:0] expm1_full();
        logic [63:0] u, t, t2, t3, t4;
        u  = (64'd1 << (Q + 6)) / 12;
        t  = (u * LN2_Q30) >> 30;
        t2 = (t * t) >> 30;
        t3 = (t2 * t) >> 30;
        t4 = (t3 * t) >> 30;
        return t + t2 / 2 + t3 / 6 + t4 / 24;
    endfunction

    localparam logic [63:0]      G64     = expm1_full();
    localparam logic [G_W-1:0]   G_SEMI  = G_W'(G64);
    localparam logic [63:0]      RCP64   = (64'd1 << RCP_SH) / (2 * G64);
    localparam logic [RCP_W-1:0] RECIP   = RCP_W'(RCP64);

    // floor(x / 3) by reciprocal multiply, exact for any 32-bit x
    function automatic logic [31:0] div3(input logic [31:0] x);
        logic [63:0] p;
        p = 64'(x) * 64'h0000_0000_AAAA_AAAB;
        return 32'(p >> 33);
    endfunction

endpackage

@@ sv/f2m_log2.sv @@
// four-stage log2 of an unsigned integer: normalize, table read, interpolate, sum
// depends on f2m_pkg (table and widths)
module f2m_log2 import f2m_pkg::*; (
    input  logic              i_clk,
    input  logic [3:0]        i_en,
    input  logic [FREQ_W-1:0] i_value,
    output logic [LOG_W-1:0]  o_log
);

    logic [EXP_W-1:0]     n_exp;
    logic [FREQ_W-1:0]    n_mant;
    logic [EXP_W-1:0]     r_a_exp;
    logic [MANT_W-1:0]    r_a_frac;

    logic [N_MUL_W-1:0]   n_prod;
    logic [TAB_IDX_W-1:0] n_idx;
    logic [TAB_W-1:0]     n_lo;
    logic [TAB_W-1:0]     n_hi;
    logic [EXP_W-1:0]     r_b_exp;
    logic [TAB_W-1:0]     r_b_lo;
    logic [TAB_W-1:0]     r_b_diff;
    logic [MANT_W-1:0]    r_b_rem;

    logic [TAB_W+MANT_W-1:0] n_ip;
    logic [EXP_W-1:0]     r_c_exp;
    logic [TAB_W-1:0]     r_c_lo;
    logic [TAB_W-1:0]     r_c_ip;
    logic [LOG_W-1:0]     r_log;

    // leading one search
    always_comb begin
        n_exp = '0;
        for (int b = 0; b < FREQ_W; b++) begin
            if (i_value[b]) begin
                n_exp = EXP_W'(b);
            end
        end
        n_mant = i_value << (EXP_W'(MANT_W) - n_exp);
    end

    always_comb begin
        n_prod = N_MUL_W'(r_a_frac) * N_MUL_W'(LOG_TABLE_ENTRIES);
        n_idx  = TAB_IDX_W'(n_prod >> MANT_W);
        if (n_idx >= TAB_IDX_W'(LOG_TABLE_ENTRIES)) begin
            n_idx = TAB_IDX_W'(LOG_TABLE_ENTRIES - 1);
        end
        n_lo = LOG_TAB[n_idx];
        n_hi = LOG_TAB[n_idx + TAB_IDX_W'(1)];
        n_ip = (TAB_W + MANT_W)'(r_b_diff) * (TAB_W + MANT_W)'(r_b_rem);
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_a_exp  <= n_exp;
            r_a_frac <= n_mant[MANT_W-1:0];
        end
        if (i_en[1]) begin
            r_b_exp  <= r_a_exp;
            r_b_lo   <= n_lo;
            r_b_diff <= (n_hi < n_lo) ? '0 : n_hi - n_lo;
            r_b_rem  <= n_prod[MANT_W-1:0];
        end
        if (i_en[2]) begin
            r_c_exp <= r_b_exp;
            r_c_lo  <= r_b_lo;
            r_c_ip  <= TAB_W'(n_ip >> MANT_W);
        end
        if (i_en[3]) begin
            r_log <= (LOG_W'(r_c_exp) << Q) + LOG_W'(r_c_lo) + LOG_W'(r_c_ip);
        end
    end

    assign o_log = r_log;

endmodule

@@ sv/f2m_expm1.sv @@
// seven-stage series for 2^(d/12)-1 and the bend numerator
// depends on f2m_pkg (div3, constants)
module f2m_expm1 import f2m_pkg::*; (
    input  logic           i_clk,
    input  logic [6:0]     i_en,
    input  logic [Q-1:0]   i_d,
    input  logic           i_minus,
    output logic [G_W-1:0] o_num
);

    logic [U_W-1:0]  r_u;
    logic [T_W-1:0]  r_t1;
    logic [T_W-1:0]  r_t2_t;
    logic [T2_W-1:0] r_t2;
    logic [T_W-1:0]  r_t3_t;
    logic [T2_W-1:0] r_t3_t2;
    logic [T3_W-1:0] r_t3;
    logic [T_W-1:0]  r_t4_t;
    logic [T2_W-1:0] r_t4_t2;
    logic [T4_W-1:0] r_t4;
    logic [T3_W-1:0] r_q3;
    logic [T_W-1:0]  r_t5_t;
    logic [T2_W-1:0] r_t5_t2;
    logic [T3_W-1:0] r_t5_q3;
    logic [T4_W-1:0] r_q4;
    logic [G_W-1:0]  r_num;

    logic [63:0]     n_pt;
    logic [63:0]     n_pt2;
    logic [63:0]     n_pt3;
    logic [63:0]     n_pt4;
    logic [31:0]     n_u;
    logic [31:0]     n_q3;
    logic [31:0]     n_q4;
    logic [E_W-1:0]  n_e;

    always_comb begin
        n_u   = div3(32'({i_d, 4'b0}));
        n_pt  = 64'(r_u) * LN2_Q30;
        n_pt2 = 64'(r_t1) * 64'(r_t1);
        n_pt3 = 64'(r_t2) * 64'(r_t2_t);
        n_pt4 = 64'(r_t3) * 64'(r_t3_t);
        n_q3  = div3(32'(r_t3 >> 1));
        n_q4  = div3(32'(r_t4 >> 3));
        n_e   = E_W'(r_t5_t) + E_W'(r_t5_t2 >> 1) + E_W'(r_t5_q3) + E_W'(r_q4);
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_u <= U_W'(n_u);
        end
        if (i_en[1]) begin
            r_t1 <= T_W'(n_pt >> 30);
        end
        if (i_en[2]) begin
            r_t2_t <= r_t1;
            r_t2   <= T2_W'(n_pt2 >> 30);
        end
        if (i_en[3]) begin
            r_t3_t  <= r_t2_t;
            r_t3_t2 <= r_t2;
            r_t3    <= T3_W'(n_pt3 >> 30);
        end
        if (i_en[4]) begin
            r_t4_t  <= r_t3_t;
            r_t4_t2 <= r_t3_t2;
            r_t4    <= T4_W'(n_pt4 >> 30);
            r_q3    <= T3_W'(n_q3);
        end
        if (i_en[5]) begin
            r_t5_t  <= r_t4_t;
            r_t5_t2 <= r_t4_t2;
            r_t5_q3 <= r_q3;
            r_q4    <= T4_W'(n_q4);
        end
        if (i_en[6]) begin
            // below the note the distance runs down from the full semitone
            if (i_minus) begin
                r_num <= (E_W'(G_SEMI) > n_e) ? G_W'(E_W'(G_SEMI) - n_e) : '0;
            end else begin
                r_num <= G_W'(n_e);
            end
        end
    end

    assign o_num = r_num;

endmodule

@@ sv/f2m_bend.sv @@
// two-stage rounded percentage: reciprocal estimate, then one correction step
// depends on f2m_pkg (G_SEMI, RECIP)
module f2m_bend import f2m_pkg::*; (
    input  logic           i_clk,
    input  logic [1:0]     i_en,
    input  logic [G_W-1:0] i_num,
    output logic [6:0]     o_bend
);

    logic [X_W-1:0]  n_x;
    logic [63:0]     n_px;
    logic [X_W-1:0]  r_x;
    logic [QE_W-1:0] r_qe;
    logic [QE_W:0]   n_q1;
    logic [X_W-1:0]  n_chk;
    logic [QE_W:0]   n_q;
    logic [6:0]      r_bend;

    always_comb begin
        n_x   = (X_W'(i_num) << 7) + (X_W'(i_num) << 6) + (X_W'(i_num) << 3) + X_W'(G_SEMI);
        n_px  = 64'(n_x) * 64'(RECIP);
        n_q1  = (QE_W + 1)'(r_qe) + (QE_W + 1)'(1);
        n_chk = X_W'(n_q1) * (X_W'(G_SEMI) << 1);
        n_q   = (r_x >= n_chk) ? n_q1 : (QE_W + 1)'(r_qe);
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_x  <= n_x;
            r_qe <= QE_W'(n_px >> RCP_SH);
        end
        if (i_en[1]) begin
            r_bend <= (n_q > (QE_W + 1)'(100)) ? 7'd100 : 7'(n_q);
        end
    end

    assign o_bend = r_bend;

endmodule

@@ sv/frequency_to_midi_note.sv @@
// top level: frequency to nearest MIDI note with pitch bend, 15-stage pipeline
// depends on f2m_pkg, f2m_log2, f2m_expm1, f2m_bend
//
// usage
// - input channel: i_valid / o_stall with i_freq_in in 1/16 Hz; a transaction
//   happens on a rising edge with i_valid high and o_stall low
// - output channel: o_valid / i_stall with o_note, o_bend_minus,
//   o_bend_percent and o_status; one result per input, in order
// - config channel: i_cfg_valid / o_cfg_ready (always ready) with a register
//   index and data; write only while the pipeline is empty
// - throughput: one frequency can enter every cycle while o_stall is low,
//   and an item passes through the 15 register stages in order before
//   o_valid rises for it; each stage holds one item
// - stall: each stage advances when it is empty or the next one advances, so
//   bubbles close up and new items are taken while a result waits; o_stall is
//   raised only once every stage holds an item and the output is stalled
// - reset: all valid bits clear, registers return to 8372 / 120 / 206592
// - status other than ok forces note, bend sign and bend to zero
module frequency_to_midi_note import f2m_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [FREQ_W-1:0] i_freq_in,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [6:0]        o_note,
    output logic              o_bend_minus,
    output logic [6:0]        o_bend_percent,
    output logic [1:0]        o_status,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [1:0]        i_cfg_index,
    input  logic [FREQ_W-1:0] i_cfg_data
);

    localparam int NS = 15;

    // config registers
    logic [REF_W-1:0]  r_reference_freq;
    logic [FREQ_W-1:0] r_min_freq;
    logic [FREQ_W-1:0] r_max_freq;

    // pipeline control
    logic [NS-1:0] r_v;
    logic [NS-1:0] en;
    logic          in_acc;

    // sideband carried alongside the datapath
    t_side r_side [0:NS-1];
    t_side n_side [0:NS-1];

    // stage 0 payload
    logic [FREQ_W-1:0] r_f;
    logic [REF_W-1:0]  r_ref;
    logic [1:0]        n_status;

    // log results and stage 5
    logic [LOG_W-1:0]  log_f;
    logic [LOG_W-1:0]  log_r;
    logic signed [L_W-1:0]   n_l;
    logic signed [S_W-1:0]   n_s;
    logic signed [S_W-1:0]   n_sr;
    logic signed [RND_W-1:0] n_rnd;
    logic [6:0]        n_note;
    logic [Q-1:0]      r_d;

    logic [G_W-1:0]    num;
    logic [6:0]        bend;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reference_freq <= REF_RST;
            r_min_freq       <= MIN_FREQ_RST;
            r_max_freq       <= MAX_FREQ_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_REFERENCE: r_reference_freq <= i_cfg_data[REF_W-1:0];
                REG_MIN_FREQ:  r_min_freq       <= i_cfg_data;
                REG_MAX_FREQ:  r_max_freq       <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // a stage loads when it is empty or its item moves on
    always_comb begin
        en[NS-1] = !r_v[NS-1] || !i_stall;
        for (int k = NS - 2; k >= 0; k--) begin
            en[k] = !r_v[k] || en[k+1];
        end
    end

    assign o_stall = !en[0];
    assign in_acc  = i_valid && en[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (en[0]) begin
                r_v[0] <= in_acc;
            end
            for (int k = 1; k < NS; k++) begin
                if (en[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    // range check; zero is always below range, and the low test wins
    always_comb begin
        if (i_freq_in == '0 || i_freq_in < r_min_freq) begin
            n_status = ST_BELOW;
        end else if (i_freq_in > r_max_freq) begin
            n_status = ST_ABOVE;
        end else begin
            n_status = ST_OK;
        end
    end

    // stage 5: fracmidi = 12 * (log2 f - log2 ref + offset), q24
    always_comb begin
        n_l   = L_W'(log_f) - L_W'(log_r) + (L_W'(10 - FREQ_FRAC_BITS) << Q);
        n_s   = (S_W'(n_l) <<< 3) + (S_W'(n_l) <<< 2);
        n_sr  = n_s + (S_W'(1) <<< (Q - 1));
        n_rnd = RND_W'(n_sr >>> Q);
        if (n_rnd < 0) begin
            n_note = 7'd0;
        end else if (n_rnd > RND_W'(127)) begin
            n_note = 7'd127;
        end else begin
            n_note = 7'(n_rnd);
        end
    end

    always_comb begin
        n_side[0] = '0;
        for (int k = 1; k < NS; k++) begin
            n_side[k] = r_side[k-1];
        end
        n_side[0].status = n_status;
        n_side[5].note   = (r_side[4].status == ST_OK) ? n_note : 7'd0;
        n_side[5].minus  = (r_side[4].status == ST_OK) ? n_s[Q-1] : 1'b0;
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < NS; k++) begin
            if (en[k]) begin
                r_side[k] <= n_side[k];
            end
        end
        if (en[0]) begin
            r_f   <= i_freq_in;
            r_ref <= (r_reference_freq == '0) ? REF_W'(1) : r_reference_freq;
        end
        if (en[5]) begin
            r_d <= n_s[Q-1:0];
        end
    end

    f2m_log2 u_log_f (
        .i_clk   (i_clk),
        .i_en    (en[4:1]),
        .i_value (r_f),
        .o_log   (log_f)
    );

    f2m_log2 u_log_r (
        .i_clk   (i_clk),
        .i_en    (en[4:1]),
        .i_value (FREQ_W'(r_ref)),
        .o_log   (log_r)
    );

    f2m_expm1 u_expm1 (
        .i_clk   (i_clk),
        .i_en    (en[12:6]),
        .i_d     (r_d),
        .i_minus (r_side[11].minus),
        .o_num   (num)
    );

    f2m_bend u_bend (
        .i_clk  (i_clk),
        .i_en   (en[14:13]),
        .i_num  (num),
        .o_bend (bend)
    );

    assign o_valid        = r_v[NS-1];
    assign o_note         = r_side[NS-1].note;
    assign o_bend_minus   = r_side[NS-1].minus;
    assign o_status       = r_side[NS-1].status;
    assign o_bend_percent = (r_side[NS-1].status == ST_OK) ? bend : 7'd0;

endmodule

@@ sv/f2m_checker.sv @@
// port-level checker for frequency_to_midi_note, attached by bind
// depends on assert_macros.svh and f2m_pkg
`include "assert_macros.svh"

module f2m_checker import f2m_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic [6:0]  o_note,
    input logic        o_bend_minus,
    input logic [6:0]  o_bend_percent,
    input logic [1:0]  o_status
);

    // an error result carries nothing else
    `ASSERT_IMPL(a_err_zero, o_valid && o_status != ST_OK,
        o_note == 7'd0 && !o_bend_minus && o_bend_percent == 7'd0)

    // bend never passes one full semitone
    `ASSERT_IMPL(a_bend_max, o_valid, o_bend_percent <= 7'd100)

    // input backs up only when the whole pipe is full behind a stalled output
    `ASSERT_IMPL(a_stall_src, o_stall, o_valid && i_stall)

    // a stalled result is held
    `ASSERT_NEXT(a_out_hold, o_valid && i_stall,
        o_valid && $stable(o_note) && $stable(o_bend_percent) && $stable(o_status))

endmodule

bind frequency_to_midi_note f2m_checker u_f2m_checker (.*);

@@ dv/tb_top.sv @@
// self-checking testbench for frequency_to_midi_note: directed table, then random frequencies
// depends on f2m_pkg and the frequency_to_midi_note rtl; predicts each untyped result in fixed point
`timescale 1ns / 1ps

module tb_top;
    import f2m_pkg::*;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_valid;
    logic              o_stall;
    logic [FREQ_W-1:0] i_freq_in;
    logic              o_valid;
    logic              i_stall;
    logic [6:0]        o_note;
    logic              o_bend_minus;
    logic [6:0]        o_bend_percent;
    logic [1:0]        o_status;
    logic              i_cfg_valid;
    logic              o_cfg_ready;
    logic [1:0]        i_cfg_index;
    logic [FREQ_W-1:0] i_cfg_data;

    frequency_to_midi_note i_dut (.*);

    // one predicted result
    typedef struct {
        logic [6:0] note;
        logic       minus;
        logic [6:0] percent;
        logic [1:0] status;
        logic       typed;   // row gave the result by hand
    } t_note_res;

    t_note_res   note_queue[$];
    int          n_errors;
    bit          stim_done;

    // local copy of the registers
    logic [15:0] cur_ref;
    logic [17:0] cur_min;
    logic [17:0] cur_max;

    // log2 mantissa table, built here from integers
    logic [31:0] semi_log_tab [0:LOG_TABLE_ENTRIES];

    function automatic logic [31:0] mant_log2(input logic [63:0] x0);
        logic [63:0] x;
        logic [31:0] res;
        x = x0;
        res = 0;
        if (x >= 64'h8000_0000) return 32'h0100_0000;
        for (int b = 23; b >= 0; b--) begin
            x = (x * x) >> 30;
            if (x >= 64'h8000_0000) begin
                res[b] = 1'b1;
                x = x >> 1;
            end
        end
        return res;
    endfunction

    function automatic longint int_log2(input logic [63:0] v);
        int          e;
        logic [63:0] m, fr, p, idx, r, lo, hi;
        e = 0;
        while (e < 31 && (v >> (e + 1)) != 0) e++;
        m   = (v << (30 - e)) & 64'h7FFF_FFFF;
        fr  = m - 64'h4000_0000;
        p   = fr * LOG_TABLE_ENTRIES;
        idx = p >> 30;
        if (idx >= LOG_TABLE_ENTRIES) idx = LOG_TABLE_ENTRIES - 1;
        r   = p & 64'h3FFF_FFFF;
        lo  = semi_log_tab[idx];
        hi  = semi_log_tab[idx + 1];
        if (hi < lo) hi = lo;
        return longint'(e) * (64'sd1 << 24) + longint'(lo + (((hi - lo) * r) >> 30));
    endfunction

    function automatic logic [63:0] semi_expm1(input logic [63:0] d);
        logic [63:0] u, t, t2, t3, t4;
        u  = (d << 6) / 12;
        t  = (u * 64'd744261118) >> 30;
        t2 = (t * t) >> 30;
        t3 = (t2 * t) >> 30;
        t4 = (t3 * t) >> 30;
        return t + t2 / 2 + t3 / 6 + t4 / 24;
    endfunction

    function automatic longint floor24(input longint a);
        if (a >= 0) return a >>> 24;
        return -longint'((longint'(-a) + (64'sd1 << 24) - 1) >>> 24);
    endfunction

    function automatic t_note_res predict_note(input logic [17:0] f);
        t_note_res   res;
        logic [63:0] rf, d, g, e, num, bend;
        longint      lg, s, lo, rnd;
        res = '{7'd0, 1'b0, 7'd0, ST_OK, 1'b0};
        rf  = (cur_ref == 0) ? 64'd1 : 64'(cur_ref);
        if (f == 0 || f < cur_min) begin
            res.status = ST_BELOW;
            return res;
        end
        if (f > cur_max) begin
            res.status = ST_ABOVE;
            return res;
        end
        lg  = int_log2(64'(f)) - int_log2(rf) + longint'(10 - FREQ_FRAC_BITS) * (64'sd1 << 24);
        s   = 12 * lg;
        lo  = floor24(s);
        d   = 64'(s - lo * (64'sd1 << 24));
        rnd = floor24(s + (64'sd1 << 23));
        g   = semi_expm1(64'd1 << 24);
        e   = semi_expm1(d);
        res.minus = (d >= (64'd1 << 23));
        num  = res.minus ? ((g > e) ? g - e : 64'd0) : e;
        bend = (200 * num + g) / (2 * g);
        if (bend > 100) bend = 100;
        if (rnd < 0) rnd = 0;
        if (rnd > 127) rnd = 127;
        res.note    = 7'(rnd);
        res.percent = 7'(bend);
        return res;
    endfunction

    // directed rows: frequency plus, for error rows, a typed status
    typedef struct {
        logic [17:0] freq;
        logic        typed;
        logic [1:0]  status;
    } t_freq_row;

    t_freq_row freq_table [] = '{
        '{18'd0,      1'b1, ST_BELOW},   // zero frequency
        '{18'd119,    1'b1, ST_BELOW},
        '{18'd120,    1'b0, ST_OK},      // lowest accepted
        '{18'd206592, 1'b0, ST_OK},      // highest accepted
        '{18'd206593, 1'b1, ST_ABOVE},
        '{18'h3FFFF,  1'b1, ST_ABOVE},   // all ones
        '{18'd7040,   1'b0, ST_OK},      // 440 hz, near a semitone
        '{18'd3520,   1'b0, ST_OK},
        '{18'd7250,   1'b0, ST_OK},      // between semitones
        '{18'd7460,   1'b0, ST_OK},
        '{18'd131,    1'b0, ST_OK},
        '{18'd100000, 1'b0, ST_OK},
        '{18'd1,      1'b1, ST_BELOW},
        '{18'd4096,   1'b0, ST_OK},
        '{18'd8192,   1'b0, ST_OK}
    };

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // hard limit on run time
    initial begin
        #20ms;
        $display("Verification failed");
        $finish;
    end

    // receiver: stalls on its own pattern, checks each result transaction
    int stall_mode;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
            stall_mode <= 0;
        end else begin
            if (o_valid && !i_stall) begin
                if (note_queue.size() == 0) begin
                    $error("unexpected result transaction");
                    n_errors++;
                end else begin
                    t_note_res x;
                    x = note_queue.pop_front();
                    if (o_status !== x.status) begin
                        $error("status exp %0d act %0d", x.status, o_status);
                        n_errors++;
                    end
                    if (!x.typed || x.status != ST_OK) begin
                        if (o_note !== x.note) begin
                            $error("note exp %0d act %0d", x.note, o_note);
                            n_errors++;
                        end
                        if (o_bend_minus !== x.minus) begin
                            $error("bend_minus exp %0d act %0d", x.minus, o_bend_minus);
                            n_errors++;
                        end
                        if (o_bend_percent !== x.percent) begin
                            $error("bend_percent exp %0d act %0d", x.percent, o_bend_percent);
                            n_errors++;
                        end
                    end
                end
            end
            // pattern changes now and then: none, light, heavy
            if ($urandom_range(0, 63) == 0) stall_mode <= $urandom_range(0, 2);
            case (stall_mode)
                0: i_stall <= 1'b0;
                1: i_stall <= ($urandom_range(0, 3) == 0);
                default: i_stall <= ($urandom_range(0, 3) != 0);
            endcase
        end
    end

    // drive one frequency transaction and record its prediction
    task automatic send_freq(input logic [17:0] f, input t_note_res exp_res);
        i_valid   <= 1'b1;
        i_freq_in <= f;
        do @(posedge i_clk); while (o_stall);
        note_queue.push_back(exp_res);
    endtask

    task automatic idle_cycles(input int n);
        i_valid <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    // wait until the pipeline has drained, then a margin for latency
    task automatic drain_pipe();
        idle_cycles(1);
        while (note_queue.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [17:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            REG_REFERENCE: cur_ref = val[15:0];
            REG_MIN_FREQ:  cur_min = val;
            REG_MAX_FREQ:  cur_max = val;
            default: ;
        endcase
    endtask

    // random frequency: mostly in range, some full-width and edge values
    function automatic logic [17:0] rand_freq();
        case ($urandom_range(0, 9))
            0: return 18'($urandom);
            1: return 18'(cur_min + $urandom_range(0, 2) - 1);
            2: return 18'(cur_max + $urandom_range(0, 2) - 1);
            default: return 18'($urandom_range(cur_min, cur_max));
        endcase
    endfunction

    task automatic random_phase(input int n);
        int burst;
        while (n > 0) begin
            burst = $urandom_range(1, 24);
            while (burst > 0 && n > 0) begin
                logic [17:0] f;
                f = rand_freq();
                send_freq(f, predict_note(f));
                burst--;
                n--;
            end
            if ($urandom_range(0, 2) != 0) idle_cycles($urandom_range(1, 6));
        end
    endtask

    initial begin
        t_note_res r;
        for (int i = 0; i <= LOG_TABLE_ENTRIES; i++)
            semi_log_tab[i] = mant_log2(64'h4000_0000 + ((64'(i) << 30) / LOG_TABLE_ENTRIES));
        n_errors    = 0;
        stim_done   = 0;
        cur_ref     = 16'd8372;
        cur_min     = 18'd120;
        cur_max     = 18'd206592;
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_freq_in   = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = REG_REFERENCE;
        i_cfg_data  = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table at reset settings
        foreach (freq_table[k]) begin
            r = predict_note(freq_table[k].freq);
            if (freq_table[k].typed) begin
                r = '{7'd0, 1'b0, 7'd0, freq_table[k].status, 1'b1};
            end
            send_freq(freq_table[k].freq, r);
        end
        drain_pipe();

        random_phase(250);
        drain_pipe();   // sender holds off until every result is back

        // wide limits, reduced reference: notes saturate high
        write_reg(REG_REFERENCE, 18'd1024);
        write_reg(REG_MIN_FREQ, 18'd0);
        write_reg(REG_MAX_FREQ, 18'h3FFFF);
        random_phase(200);
        drain_pipe();

        // highest reference, zero reference treated as one
        write_reg(REG_REFERENCE, 18'd65535);
        random_phase(150);
        drain_pipe();
        write_reg(REG_REFERENCE, 18'd0);
        send_freq(18'd0, predict_note(18'd0));
        random_phase(50);
        drain_pipe();

        // crossed limits: below test wins
        write_reg(REG_REFERENCE, 18'd8372);
        write_reg(REG_MIN_FREQ, 18'd200000);
        write_reg(REG_MAX_FREQ, 18'd1000);
        random_phase(50);
        drain_pipe();

        write_reg(REG_MIN_FREQ, 18'd500);
        write_reg(REG_MAX_FREQ, 18'd60000);
        random_phase(150);
        drain_pipe();

        if (n_errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+sv
sv/f2m_pkg.sv
sv/f2m_log2.sv
sv/f2m_expm1.sv
sv/f2m_bend.sv
sv/frequency_to_midi_note.sv
sv/f2m_checker.sv
dv/tb_top.sv
